// ----- hdl/sspg_pkg.sv -----
// Shared constants, types and helpers for the step-pulse generator.
// No dependencies.
`default_nettype none
package sspg_pkg;
  localparam int NUM_MOTORS_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SCALE_W = 13;
  localparam int PPU_W   = 16;
  localparam int CFG_W   = 16;
  localparam int SEG_W   = 33;
  localparam logic [SCALE_W-1:0] SCALE_RST = 13'd34;
  localparam logic [PPU_W-1:0]   PPU_RST   = 16'd160;
  localparam logic CFG_SCALE = 1'b0;
  localparam logic CFG_PPU   = 1'b1;
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_PUSH = 1'b1;

  typedef struct packed {
    logic       is_push;
    logic [1:0] motor;
    logic [SEG_W-1:0] seg;
  } cmd_t;

  function automatic logic [15:0] mag16(input logic [15:0] v);
    logic [15:0] n;
    begin
      n = 16'd0 - v;
      mag16 = v[15] ? n : v;
    end
  endfunction
endpackage
`default_nettype wire

// ----- hdl/sspg_ram.sv -----
// Generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module sspg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- hdl/sspg_front.sv -----
// Front end: accepts items and packs them into commands for the back end.
// Uses sspg_pkg.
`default_nettype none
module sspg_front (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      valid,
  output logic                     ready,
  input  wire                      kind,
  input  wire  [1:0]               motor,
  input  wire                      seg_running,
  input  wire  [15:0]              seg_speed,
  input  wire  [15:0]              seg_distance,
  output logic                     cmd_valid,
  input  wire                      cmd_ready,
  output sspg_pkg::cmd_t           cmd
);
  // two-entry queue
  sspg_pkg::cmd_t q [2];
  logic [1:0] cnt;
  logic       wp, rp;
  logic       push, pop;

  assign ready = (cnt != 2'd2);
  assign push  = valid && ready;
  assign cmd_valid = (cnt != 2'd0);
  assign pop   = cmd_valid && cmd_ready;
  assign cmd   = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0; wp <= 1'b0; rp <= 1'b0;
    end else begin
      if (push) begin
        q[wp] <= '{is_push: (kind == sspg_pkg::KIND_PUSH), motor: motor,
                   seg: {seg_running, seg_speed, seg_distance}};
        wp <= ~wp;
      end
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sspg_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module sspg_div (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [16:0] num,
  input  wire  [15:0] den,
  output logic        done,
  output logic [16:0] quo
);
  logic [16:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [17:0] trial;
  assign trial = {rem[16:0], quo[16]} - {2'b0, den};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; cnt <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; rem <= 17'd0; quo <= num; cnt <= 5'd17;
      end else if (busy) begin
        if (!trial[17]) rem <= trial[16:0];
        else rem <= {rem[15:0], quo[16]};
        quo <= {quo[15:0], ~trial[17]};
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- hdl/sspg_back.sv -----
// Back end: segment queues, per-motor tick sequencing and segment loading.
// Uses sspg_pkg, sspg_ram and sspg_div.
`default_nettype none
module sspg_back #(
  parameter int NUM_MOTORS  = sspg_pkg::NUM_MOTORS_DEF,
  parameter int QUEUE_DEPTH = sspg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cmd_valid,
  output logic                         cmd_ready,
  input  wire sspg_pkg::cmd_t          cmd,
  input  wire  [sspg_pkg::SCALE_W-1:0] scale,
  input  wire  [sspg_pkg::PPU_W-1:0]   ppu,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [3:0]                   step_levels,
  output logic [3:0]                   dir_levels,
  output logic [3:0]                   queue_empty,
  output logic                         push_dropped
);
  localparam int MW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int RA = MW + AW;
  localparam logic [2:0] S_IDLE = 3'd0, S_TICK = 3'd1, S_RD = 3'd2,
                         S_RDW = 3'd3, S_DIV = 3'd4, S_MUL = 3'd5, S_OUT = 3'd6;

  logic [2:0]  state;
  logic [15:0] tcnt [NUM_MOTORS];
  logic [15:0] per  [NUM_MOTORS];
  logic [15:0] pl   [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] lvl, dir;
  logic [FW-1:0] fill [NUM_MOTORS];
  logic [AW-1:0] head [NUM_MOTORS];
  logic [MW-1:0] m;
  logic          drop;
  logic [sspg_pkg::SEG_W-1:0] seg;
  logic [31:0]   prod;

  logic          we;
  logic [RA-1:0] waddr, raddr;
  logic [sspg_pkg::SEG_W-1:0] rdata;
  logic [AW:0]   wsum;
  logic [AW-1:0] wptr;
  logic [MW-1:0] cm;
  logic          cm_ok;

  assign cm    = MW'(cmd.motor);
  assign cm_ok = ({30'd0, cmd.motor} < NUM_MOTORS) && (fill[cm] < FW'(QUEUE_DEPTH));
  assign wsum  = {1'b0, head[cm]} + (AW+1)'(fill[cm]);
  // wrap the tail position around the queue depth
  assign wptr  = (32'(wsum) >= QUEUE_DEPTH) ? AW'(wsum - (AW+1)'(QUEUE_DEPTH)) : AW'(wsum);
  assign we    = (state == S_IDLE) && cmd_valid && cmd.is_push && cm_ok;
  assign waddr = {cm, wptr};
  assign raddr = {m, head[m]};
  assign cmd_ready = (state == S_IDLE);

  sspg_ram #(.WIDTH(sspg_pkg::SEG_W), .DEPTH(2 ** RA)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(cmd.seg), .raddr(raddr), .rdata(rdata));

  logic        dstart, ddone;
  logic [16:0] dquo;
  logic [16:0] dnum;
  logic [15:0] spd, dst;
  logic [16:0] q16;
  logic [15:0] fl;
  assign spd = sspg_pkg::mag16(seg[31:16]);
  assign dst = sspg_pkg::mag16(seg[15:0]);
  assign dnum = {1'b0, scale, 3'd0} + {3'd0, scale, 1'b0};
  sspg_div u_div (.clk(clk), .rst(rst), .start(dstart),
    .num(dnum), .den(spd), .done(ddone), .quo(dquo));
  assign dstart = (state == S_RDW) && rdata[32] && (rdata[31:16] != 16'd0);
  assign fl = {4'd0, scale[12:1]};
  assign q16 = (spd == 16'd0 || dquo[16]) ? 17'h0FFFF : dquo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; m <= '0;
      lvl <= '0; dir <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        tcnt[i] <= '0; per[i] <= '0; pl[i] <= '0; fill[i] <= '0; head[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: if (cmd_valid) begin
          m <= '0; drop <= 1'b0;
          if (cmd.is_push) begin
            drop <= !cm_ok;
            if (cm_ok) fill[cm] <= fill[cm] + FW'(1);
            state <= S_OUT;
          end else state <= S_TICK;
        end
        S_TICK: begin
          if (tcnt[m] == per[m]) begin
            tcnt[m] <= '0;
            if (pl[m] != 16'd0) begin
              lvl[m] <= ~lvl[m];
              if (lvl[m]) pl[m] <= pl[m] - 16'd1;
            end else if (fill[m] == '0) begin
              per[m] <= 16'd1;
            end else begin
              state <= S_RD;
            end
          end else tcnt[m] <= tcnt[m] + 16'd1;
          if (!(tcnt[m] == per[m] && pl[m] == 16'd0 && fill[m] != '0)) begin
            if (32'(m) == NUM_MOTORS - 1) state <= S_OUT;
            else m <= m + MW'(1);
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          seg <= rdata;
          head[m] <= (32'(head[m]) == QUEUE_DEPTH - 1) ? '0 : head[m] + AW'(1);
          fill[m] <= fill[m] - FW'(1);
          if (!rdata[32]) begin
            per[m] <= 16'd1; pl[m] <= 16'd0;
            if (32'(m) == NUM_MOTORS - 1) state <= S_OUT;
            else begin m <= m + MW'(1); state <= S_TICK; end
          end else begin
            dir[m] <= !rdata[31] || !rdata[15];
            state <= S_DIV;
          end
        end
        S_DIV: if (spd == 16'd0 || ddone) begin
          per[m] <= (q16[15:0] < fl) ? fl : q16[15:0];
          prod <= {16'd0, dst} * {16'd0, ppu};
          state <= S_MUL;
        end
        S_MUL: begin
          pl[m] <= prod[15:0];
          if (32'(m) == NUM_MOTORS - 1) state <= S_OUT;
          else begin m <= m + MW'(1); state <= S_TICK; end
        end
        S_OUT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          push_dropped <= drop;
          for (int i = 0; i < 4; i++) begin
            step_levels[i] <= (i < NUM_MOTORS) ? lvl[i % NUM_MOTORS] : 1'b0;
            dir_levels[i]  <= (i < NUM_MOTORS) ? dir[i % NUM_MOTORS] : 1'b0;
            queue_empty[i] <= (i < NUM_MOTORS) ? (fill[i % NUM_MOTORS] == '0) : 1'b0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_OUT)) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ----- hdl/stepper_segment_pulse_generator_core.sv -----
// Top level of the four-axis step-pulse generator: config, front, back.
// Uses sspg_pkg, sspg_front, sspg_back.
//  channel | direction | handshake
//  in      | input     | valid / ready
//  out     | output    | out_valid / out_ready
//  cfg     | input     | cfg_we
// A push goes from idle straight to the output state; a tick visits each
// motor in turn; a segment load reads the queue RAM, then runs the 17-step
// bit-serial divider and a multiply (a stop segment skips both, zero speed the divider).
// Reset is synchronous and clears all control state; queue RAM is not cleared.
// The front queue takes new items while the back end works or output stalls.
`default_nettype none
module stepper_segment_pulse_generator_core #(
  parameter int NUM_MOTORS  = sspg_pkg::NUM_MOTORS_DEF,
  parameter int QUEUE_DEPTH = sspg_pkg::QUEUE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire        cfg_index,
  input  wire [sspg_pkg::CFG_W-1:0] cfg_data,
  input  wire        valid,
  output logic       ready,
  input  wire        kind,
  input  wire [1:0]  motor,
  input  wire        seg_running,
  input  wire [15:0] seg_speed,
  input  wire [15:0] seg_distance,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [3:0] step_levels,
  output logic [3:0] dir_levels,
  output logic [3:0] queue_empty,
  output logic       push_dropped
);
  logic [sspg_pkg::SCALE_W-1:0] scale;
  logic [sspg_pkg::PPU_W-1:0]   ppu;
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= sspg_pkg::SCALE_RST; ppu <= sspg_pkg::PPU_RST;
    end else if (cfg_we) begin
      if (cfg_index == sspg_pkg::CFG_SCALE) scale <= cfg_data[sspg_pkg::SCALE_W-1:0];
      else ppu <= cfg_data;
    end
  end

  logic cmd_valid, cmd_ready;
  sspg_pkg::cmd_t cmd;
  sspg_front u_front (.clk(clk), .rst(rst), .valid(valid), .ready(ready), .kind(kind),
    .motor(motor), .seg_running(seg_running), .seg_speed(seg_speed),
    .seg_distance(seg_distance), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd));
  sspg_back #(.NUM_MOTORS(NUM_MOTORS), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .scale(scale), .ppu(ppu), .out_valid(out_valid), .out_ready(out_ready),
    .step_levels(step_levels), .dir_levels(dir_levels), .queue_empty(queue_empty),
    .push_dropped(push_dropped));
endmodule
`default_nettype wire

// ----- hdl/sspg_checker.sv -----
// Port-level checks for the step-pulse generator.
// Bound to stepper_segment_pulse_generator_core.
`default_nettype none
module sspg_checker (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire [3:0] queue_empty,
  input wire       push_dropped
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(queue_empty)) else $error("out held");
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) && out_valid |-> queue_empty == 4'hF) else $error("empty after reset");
  a_drop_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(push_dropped)) else $error("drop held");
endmodule
bind stepper_segment_pulse_generator_core sspg_checker u_chk (.clk(clk), .rst(rst),
  .out_valid(out_valid), .out_ready(out_ready), .queue_empty(queue_empty),
  .push_dropped(push_dropped));
`default_nettype wire
